@@ rtl/core/pcalu_pkg.sv @@
// ----------------------------------------------------------------------------
// pcalu_pkg: shared types and constants of the coefficient ALU
// Opcode codes, register indexes, widths and the stage payload struct.
// ----------------------------------------------------------------------------
package pcalu_pkg;

  localparam int unsigned CoeffW = 64;
  localparam int unsigned ModW   = 63;
  localparam int unsigned ShW    = 6;
  localparam int unsigned IdxW   = 2;

  // Opcode field of an input item
  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_ADDMOD = 4'd2,
    OP_SUBMOD = 4'd3,
    OP_NEGMOD = 4'd4,
    OP_SHL    = 4'd5,
    OP_SHR    = 4'd6,
    OP_ROUND  = 4'd7,
    OP_CENTER = 4'd8,
    OP_NONNEG = 4'd9
  } op_t;

  // Configuration register indexes
  typedef enum logic [IdxW-1:0] {
    REG_MODULUS      = 2'd0,
    REG_SHIFT_AMOUNT = 2'd1,
    REG_ROUND_OFFSET = 2'd2
  } reg_idx_t;

  // Payload carried from stage to stage
  typedef struct packed {
    op_t               op;
    logic [CoeffW-1:0] val;
    logic              last;
  } stage_t;

endpackage

@@ rtl/core/pcalu_if.sv @@
// ----------------------------------------------------------------------------
// pcalu_if: stream interfaces of the coefficient ALU
// Input coefficient channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pcalu_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  opcode;
  logic [63:0] coeff_a;
  logic [63:0] coeff_b;
  logic        last_in;

  modport source (output valid, output opcode, output coeff_a, output coeff_b,
                  output last_in, input ready);
  modport sink   (input valid, input opcode, input coeff_a, input coeff_b,
                  input last_in, output ready);
endinterface

interface pcalu_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] coeff_out;
  logic        last_out;

  modport source (output valid, output coeff_out, output last_out, input ready);
  modport sink   (input valid, input coeff_out, input last_out, output ready);
endinterface

@@ rtl/core/pcalu_pre.sv @@
// ----------------------------------------------------------------------------
// pcalu_pre: operand stage
// Forms the pre-shift value: a+b, a-b, -a, a+h, a+m/2 or a.
// ----------------------------------------------------------------------------
module pcalu_pre (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [3:0]                    opcode,
  input  logic [pcalu_pkg::CoeffW-1:0]  coeff_a,
  input  logic [pcalu_pkg::CoeffW-1:0]  coeff_b,
  input  logic                          last_in,
  input  logic [pcalu_pkg::ModW-1:0]    modulus,
  input  logic [pcalu_pkg::ModW-1:0]    round_offset,
  output logic                          out_valid,
  output pcalu_pkg::stage_t             out_stage
);

  pcalu_pkg::op_t                 op;
  logic [pcalu_pkg::CoeffW-1:0]   opnd;
  logic [pcalu_pkg::CoeffW-1:0]   base;
  logic                           do_sub;
  pcalu_pkg::stage_t              stage_next;

  assign op = pcalu_pkg::op_t'(opcode);

  // Operand select for the single adder
  always_comb begin
    base   = coeff_a;
    opnd   = '0;
    do_sub = 1'b0;
    case (op)
      pcalu_pkg::OP_ADD, pcalu_pkg::OP_ADDMOD: begin
        opnd = coeff_b;
      end
      pcalu_pkg::OP_SUB, pcalu_pkg::OP_SUBMOD: begin
        opnd   = coeff_b;
        do_sub = 1'b1;
      end
      pcalu_pkg::OP_NEGMOD: begin
        base   = '0;
        opnd   = coeff_a;
        do_sub = 1'b1;
      end
      pcalu_pkg::OP_ROUND: begin
        opnd = {1'b0, round_offset};
      end
      pcalu_pkg::OP_CENTER: begin
        opnd = {2'b00, modulus[pcalu_pkg::ModW-1:1]};
      end
      default: begin
        opnd = '0;
      end
    endcase
    stage_next.op   = op;
    stage_next.last = last_in;
    stage_next.val  = do_sub ? (base - opnd) : (base + opnd);
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_stage <= stage_next;
    end
  end

endmodule

@@ rtl/core/pcalu_shift.sv @@
// ----------------------------------------------------------------------------
// pcalu_shift: shift stage
// Left shift for shl, arithmetic right shift for shr and round.
// ----------------------------------------------------------------------------
module pcalu_shift (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  pcalu_pkg::stage_t           in_stage,
  input  logic [pcalu_pkg::ShW-1:0]   shift_amount,
  output logic                        out_valid,
  output pcalu_pkg::stage_t           out_stage
);

  pcalu_pkg::stage_t stage_next;

  // Barrel shift
  always_comb begin
    stage_next = in_stage;
    case (in_stage.op)
      pcalu_pkg::OP_SHL: begin
        stage_next.val = in_stage.val << shift_amount;
      end
      pcalu_pkg::OP_SHR, pcalu_pkg::OP_ROUND: begin
        stage_next.val = $unsigned($signed(in_stage.val) >>> shift_amount);
      end
      default: begin
        stage_next.val = in_stage.val;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_stage <= stage_next;
    end
  end

endmodule

@@ rtl/core/pcalu_reduce.sv @@
// ----------------------------------------------------------------------------
// pcalu_reduce: modular reduction stages
// Subtract m where needed, add m back when negative, then the centering
// correction and zeroing of unused opcodes. Three register stages.
// ----------------------------------------------------------------------------
module pcalu_reduce (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  pcalu_pkg::stage_t           in_stage,
  input  logic [pcalu_pkg::ModW-1:0]  modulus,
  output logic                        out_valid,
  output pcalu_pkg::stage_t           out_stage
);

  logic [pcalu_pkg::CoeffW-1:0] m_ext;
  logic [pcalu_pkg::CoeffW-1:0] half_m;
  logic                         sub_v;
  pcalu_pkg::stage_t            sub_s;
  logic                         add_v;
  pcalu_pkg::stage_t            add_s;
  pcalu_pkg::stage_t            sub_next;
  pcalu_pkg::stage_t            add_next;
  pcalu_pkg::stage_t            fin_next;

  assign m_ext  = {1'b0, modulus};
  assign half_m = {2'b00, modulus[pcalu_pkg::ModW-1:1]};

  // Stage A: subtract m for the ops that reduce from above
  always_comb begin
    sub_next = in_stage;
    case (in_stage.op)
      pcalu_pkg::OP_ADDMOD, pcalu_pkg::OP_SHL, pcalu_pkg::OP_SHR,
      pcalu_pkg::OP_ROUND, pcalu_pkg::OP_CENTER: begin
        sub_next.val = in_stage.val - m_ext;
      end
      default: begin
        sub_next.val = in_stage.val;
      end
    endcase
  end

  // Stage B: add m back when the value is negative
  always_comb begin
    add_next = sub_s;
    case (sub_s.op)
      pcalu_pkg::OP_ADDMOD, pcalu_pkg::OP_SUBMOD, pcalu_pkg::OP_NEGMOD,
      pcalu_pkg::OP_SHL, pcalu_pkg::OP_SHR, pcalu_pkg::OP_ROUND,
      pcalu_pkg::OP_CENTER, pcalu_pkg::OP_NONNEG: begin
        add_next.val = sub_s.val[pcalu_pkg::CoeffW-1] ? (sub_s.val + m_ext) : sub_s.val;
      end
      default: begin
        add_next.val = sub_s.val;
      end
    endcase
  end

  // Stage C: undo the centering offset, unused opcodes give zero
  always_comb begin
    fin_next = add_s;
    case (add_s.op)
      pcalu_pkg::OP_CENTER: begin
        fin_next.val = add_s.val - half_m;
      end
      pcalu_pkg::OP_ADD, pcalu_pkg::OP_SUB, pcalu_pkg::OP_ADDMOD,
      pcalu_pkg::OP_SUBMOD, pcalu_pkg::OP_NEGMOD, pcalu_pkg::OP_SHL,
      pcalu_pkg::OP_SHR, pcalu_pkg::OP_ROUND, pcalu_pkg::OP_NONNEG: begin
        fin_next.val = add_s.val;
      end
      default: begin
        fin_next.val = '0;
      end
    endcase
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      sub_v     <= 1'b0;
      add_v     <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      sub_v     <= in_valid;
      add_v     <= sub_v;
      out_valid <= add_v;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      sub_s     <= sub_next;
      add_s     <= add_next;
      out_stage <= fin_next;
    end
  end

endmodule

@@ rtl/core/poly_coeff_mod_alu_unit.sv @@
// ----------------------------------------------------------------------------
// poly_coeff_mod_alu_unit: coefficient ALU for polynomials mod (x^n+1, m)
// Five-stage pipeline: operand add, shift, subtract m, add m back, finish.
// ----------------------------------------------------------------------------
// Usage:
//   coeffs  : one transfer per coefficient (opcode, coeff_a, coeff_b, last_in).
//   results : one transfer per input item (coeff_out, last_out), in order.
//   cfg_we / cfg_index / cfg_data : register writes (modulus, shift_amount,
//     round_offset); write only while the pipeline is empty.
// Throughput is one coefficient per clock while the receiver does not stall;
// the five pipeline registers lie between an input transfer and its result.
// The pipeline advances as a whole: coeffs.ready is high when the final stage
// is empty or the receiver takes its result, so a stalled receiver freezes
// every stage in place and nothing is dropped or repeated.
// Reset (rst, synchronous) clears all valid bits and sets modulus to 1,
// shift_amount and round_offset to 0.
// ----------------------------------------------------------------------------
module poly_coeff_mod_alu_unit (
  input  logic                              clk,
  input  logic                              rst,
  pcalu_in_if.sink                          coeffs,
  pcalu_out_if.source                       results,
  input  logic                              cfg_we,
  input  logic [pcalu_pkg::IdxW-1:0]        cfg_index,
  input  logic [pcalu_pkg::ModW-1:0]        cfg_data
);

  logic [pcalu_pkg::ModW-1:0] modulus;
  logic [pcalu_pkg::ShW-1:0]  shift_amount;
  logic [pcalu_pkg::ModW-1:0] round_offset;
  logic                       en;
  logic                       pre_v;
  pcalu_pkg::stage_t          pre_s;
  logic                       shf_v;
  pcalu_pkg::stage_t          shf_s;
  logic                       fin_v;
  pcalu_pkg::stage_t          fin_s;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus      <= pcalu_pkg::ModW'(1);
      shift_amount <= '0;
      round_offset <= '0;
    end else if (cfg_we) begin
      case (pcalu_pkg::reg_idx_t'(cfg_index))
        pcalu_pkg::REG_MODULUS:      modulus      <= cfg_data;
        pcalu_pkg::REG_SHIFT_AMOUNT: shift_amount <= cfg_data[pcalu_pkg::ShW-1:0];
        pcalu_pkg::REG_ROUND_OFFSET: round_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  // Global pipeline advance
  assign en           = !fin_v || results.ready;
  assign coeffs.ready = en;

  pcalu_pre u_pre (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (coeffs.valid),
    .opcode       (coeffs.opcode),
    .coeff_a      (coeffs.coeff_a),
    .coeff_b      (coeffs.coeff_b),
    .last_in      (coeffs.last_in),
    .modulus      (modulus),
    .round_offset (round_offset),
    .out_valid    (pre_v),
    .out_stage    (pre_s)
  );

  pcalu_shift u_shift (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (pre_v),
    .in_stage     (pre_s),
    .shift_amount (shift_amount),
    .out_valid    (shf_v),
    .out_stage    (shf_s)
  );

  pcalu_reduce u_reduce (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (shf_v),
    .in_stage  (shf_s),
    .modulus   (modulus),
    .out_valid (fin_v),
    .out_stage (fin_s)
  );

  // Result channel
  assign results.valid     = fin_v;
  assign results.coeff_out = fin_s.val;
  assign results.last_out  = fin_s.last;

`ifndef SYNTHESIS
  // An empty final stage never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !results.valid |-> coeffs.ready)
    else $error("input stalled with empty output stage");

  // A stall freezes the valid bits of the front stages
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(pre_v) && $stable(shf_v))
    else $error("pipeline moved during a stall");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !results.valid && !pre_v && !shf_v)
    else $error("pipeline not empty after reset");
`endif

endmodule
